@@ src/sts_pkg.sv @@
// Shared constants, codes and types for the sorted tuple set.
package sts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TUPLE_LEN   = 5;
  localparam int VAL_W       = 5;
  localparam int KEY_W       = TUPLE_LEN * VAL_W;
  localparam int RIDX_W      = 10;
  localparam int STAT_W      = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RDWAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    key_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic covered;
    logic le;
  } cmp_res_t;

endpackage

@@ src/sts_if.sv @@
// Request and response channel interfaces.
interface sts_req_if import sts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [VAL_W-1:0]  value_a;
  logic [VAL_W-1:0]  value_b;
  logic [VAL_W-1:0]  value_c;
  logic [VAL_W-1:0]  value_d;
  logic [VAL_W-1:0]  value_e;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, mode, value_a, value_b, value_c, value_d, value_e,
                  read_index, input ready);
  modport sink (input valid, mode, value_a, value_b, value_c, value_d, value_e,
                read_index, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_count;
  logic [VAL_W-1:0]  out_a;
  logic [VAL_W-1:0]  out_b;
  logic [VAL_W-1:0]  out_c;
  logic [VAL_W-1:0]  out_d;
  logic [VAL_W-1:0]  out_e;

  modport source (output valid, status, entry_count, out_a, out_b, out_c, out_d, out_e,
                  input ready);
  modport sink (input valid, status, entry_count, out_a, out_b, out_c, out_d, out_e,
                output ready);
endinterface

@@ src/sts_table.sv @@
// Tuple storage: one write port, one registered read port.
module sts_table import sts_pkg::*; (
  input  logic     clk,
  input  mem_req_t mreq,
  output key_t     rd_data
);

  key_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rd_data <= mem[mreq.raddr];
  end

endmodule

@@ src/sts_cmp.sv @@
// Shared compare unit: value-cover test and lexicographic order test.
module sts_cmp import sts_pkg::*; (
  input  key_t     stored,
  input  key_t     key,
  output cmp_res_t res
);

  logic [TUPLE_LEN-1:0] found;

  always_comb begin
    found = '0;
    for (int j = 0; j < TUPLE_LEN; j++) begin
      for (int k = 0; k < TUPLE_LEN; k++) begin
        if (stored[j*VAL_W +: VAL_W] == key[k*VAL_W +: VAL_W]) begin
          found[j] = 1'b1;
        end
      end
    end
    res.covered = &found;
    // field a sits in the top bits, so a plain compare is lexicographic
    res.le      = (stored <= key);
  end

endmodule

@@ src/sorted_tuple_set_insert.sv @@
// Top level: sequencer for sorted tuple insert, duplicate check and read.
//
//   channel | dir | payload
//   req     | in  | mode, value_a..value_e, read_index
//   rsp     | out | status, entry_count, out_a..out_e
//
// Insert: scan the n stored entries through the compare unit,
// then move the n - pos entries at and above pos up by one through the table
// and place the tuple (only the place step when nothing moves), then load the reply.
// Read: a registered RAM read, then the response load.
// Reset clears the entry count and control; RAM contents are left as is.
// A stalled response holds the block before it returns to idle.
module sorted_tuple_set_insert import sts_pkg::*; (
  input logic      clk,
  input logic      rst,
  sts_req_if.sink  req,
  sts_rsp_if.source rsp
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [CNT_W-1:0]  pos, pos_next;
  key_t              key, key_next;
  logic              dup, dup_next;
  logic              more, more_next;
  logic              vld_d, vld_d_next;
  logic [IDX_W-1:0]  raddr_d, raddr_d_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  key_t              res_val, res_val_next;
  logic              rsp_valid, rsp_valid_next;
  logic [STAT_W-1:0] rsp_status, rsp_status_next;
  logic [CNT_W-1:0]  rsp_count, rsp_count_next;
  key_t              rsp_val, rsp_val_next;

  mem_req_t mreq;
  key_t     rd_data;
  cmp_res_t cmp;

  sts_table u_table (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  sts_cmp u_cmp (
    .stored (rd_data),
    .key    (key),
    .res    (cmp)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;
  assign rsp.out_a       = rsp_val[4*VAL_W +: VAL_W];
  assign rsp.out_b       = rsp_val[3*VAL_W +: VAL_W];
  assign rsp.out_c       = rsp_val[2*VAL_W +: VAL_W];
  assign rsp.out_d       = rsp_val[1*VAL_W +: VAL_W];
  assign rsp.out_e       = rsp_val[0 +: VAL_W];

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    pos_next        = pos;
    key_next        = key;
    dup_next        = dup;
    more_next       = more;
    vld_d_next      = vld_d;
    raddr_d_next    = raddr_d;
    res_status_next = res_status;
    res_val_next    = res_val;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_count_next  = rsp_count;
    rsp_val_next    = rsp_val;
    mreq.we         = 1'b0;
    mreq.waddr      = ptr[IDX_W-1:0];
    mreq.wdata      = key;
    mreq.raddr      = ptr[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode == MODE_READ) begin
            if (CNT_W'(req.read_index) < cnt) begin
              mreq.raddr = IDX_W'(req.read_index);
              state_next = S_RDWAIT;
            end else begin
              res_status_next = STAT_RANGE;
              res_val_next    = '0;
              state_next      = S_RESP;
            end
          end else begin
            key_next   = {req.value_a, req.value_b, req.value_c, req.value_d, req.value_e};
            dup_next   = 1'b0;
            pos_next   = '0;
            ptr_next   = '0;
            vld_d_next = 1'b0;
            state_next = (cnt == '0) ? S_DECIDE : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle, compare the entry read last cycle
        vld_d_next = 1'b0;
        if (ptr != cnt) begin
          mreq.raddr = ptr[IDX_W-1:0];
          ptr_next   = ptr + 1'b1;
          vld_d_next = 1'b1;
        end
        if (vld_d) begin
          if (cmp.covered) begin
            dup_next = 1'b1;
          end
          if (cmp.le) begin
            pos_next = pos + 1'b1;
          end
        end
        if (ptr == cnt && !vld_d) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_val_next = '0;
        if (dup) begin
          res_status_next = STAT_DUP;
          state_next      = S_RESP;
        end else if (cnt == CNT_W'(TABLE_DEPTH)) begin
          res_status_next = STAT_FULL;
          state_next      = S_RESP;
        end else if (pos == cnt) begin
          state_next = S_PLACE;
        end else begin
          ptr_next   = cnt - 1'b1;
          more_next  = 1'b1;
          vld_d_next = 1'b0;
          state_next = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // read entry i, write it to i + 1 on the next cycle, walking down to pos
        vld_d_next = 1'b0;
        if (more) begin
          mreq.raddr   = ptr[IDX_W-1:0];
          raddr_d_next = ptr[IDX_W-1:0];
          vld_d_next   = 1'b1;
          if (ptr == pos) begin
            more_next = 1'b0;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end
        if (vld_d) begin
          mreq.we    = 1'b1;
          mreq.waddr = raddr_d + 1'b1;
          mreq.wdata = rd_data;
        end
        if (!more && !vld_d) begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        mreq.we         = 1'b1;
        mreq.waddr      = pos[IDX_W-1:0];
        mreq.wdata      = key;
        cnt_next        = cnt + 1'b1;
        res_status_next = STAT_OK;
        res_val_next    = '0;
        state_next      = S_RESP;
      end

      S_RDWAIT: begin
        res_status_next = STAT_OK;
        res_val_next    = rd_data;
        state_next      = S_RESP;
      end

      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_count_next  = cnt;
          rsp_val_next    = res_val;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      more      <= 1'b0;
      vld_d     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      more      <= more_next;
      vld_d     <= vld_d_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pos        <= pos_next;
    key        <= key_next;
    dup        <= dup_next;
    raddr_d    <= raddr_d_next;
    res_status <= res_status_next;
    res_val    <= res_val_next;
    rsp_status <= rsp_status_next;
    rsp_count  <= rsp_count_next;
    rsp_val    <= rsp_val_next;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |-> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (CNT_W'(mreq.waddr) <= cnt))
    else $error("table write beyond stored entries");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != STAT_OK) |-> (rsp_val == '0))
    else $error("nonzero tuple on failed item");
`endif

endmodule
